// ----- design/scba_pkg.sv -----
`default_nettype none

package scba_pkg;

  localparam int MAP_BYTES         = 1024;
  localparam int STACK_BLOCK_BYTES = 1024;

  localparam int ZONES     = 6;
  localparam int CNT_W     = 14;
  localparam int SIZE_W    = 16;
  localparam int ADDR_W    = 32;
  localparam int REQ_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int ZI_W      = $clog2(ZONES + 1);
  // Block indexes reach past the sum of six full zone counts.
  localparam int BLK_W     = 17;
  localparam int QUO_W     = CNT_W;
  localparam int PROD_W    = CNT_W + SIZE_W;
  localparam int MAP_AW    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

  // Operand width of the shared multiplier. Division by nine is a multiply by
  // ceil(2^21 / 9) and a shift by 21, exact for dividends below 2^21.
  localparam int               MUL_W      = 18;
  localparam int               DIV9_SHIFT = 21;
  localparam logic [MUL_W-1:0] DIV9_MUL   = 18'd233017;

  localparam logic [BLK_W-1:0] MAP_BITS = BLK_W'(MAP_BYTES * 8);

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_ZONE0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_ZONE1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_ZONE2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_ZONE3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_ZONE4 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_ZONE5 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_TOTAL = 3'd7;

  function automatic logic [SIZE_W-1:0] zone_size(input logic [ZI_W-1:0] z);
    logic [SIZE_W-1:0] s;
    case (z)
      3'd0:    s = SIZE_W'(4);
      3'd1:    s = SIZE_W'(8);
      3'd2:    s = SIZE_W'(18);
      3'd3:    s = SIZE_W'(36);
      3'd4:    s = SIZE_W'(512);
      default: s = SIZE_W'(STACK_BLOCK_BYTES);
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- design/scba_ram.sv -----
`default_nettype none

module scba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/size_class_bitmap_allocator_top.sv -----
`default_nettype none

// After reset the block clears the occupancy map, one byte per cycle, with in_stall
// high; configuration writes are taken during that pass.
// Allocate: skips the zones that are too small, scans the map byte by byte, then walks the zones to the block.
// Free: walks the zones up to and including the zone that holds the block.
// The result sits in an output register, so the next item can enter while it waits.
module size_class_bitmap_allocator_top import scba_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 func,
  input  logic [REQ_W-1:0]     request_bytes,
  input  logic [ADDR_W-1:0]    release_address,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  status,
  output logic [ADDR_W-1:0]    block_address,
  output logic [ADDR_W-1:0]    bytes_in_use
);

  typedef enum logic [13:0] {
    S_CLEAR    = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_LIMIT    = 14'b00000000000100,
    S_AZONE    = 14'b00000000001000,
    S_SCAN_RD  = 14'b00000000010000,
    S_SCAN_CHK = 14'b00000000100000,
    S_AMUL     = 14'b00000001000000,
    S_AACC     = 14'b00000010000000,
    S_FMUL     = 14'b00000100000000,
    S_FCMP     = 14'b00001000000000,
    S_FDIV     = 14'b00010000000000,
    S_FRD      = 14'b00100000000000,
    S_FCHK     = 14'b01000000000000,
    S_FIN      = 14'b10000000000000
  } state_t;

  state_t state;

  logic [ADDR_W-1:0] pool_base;
  logic [CNT_W-1:0]  zone_count [ZONES];
  logic [CNT_W-1:0]  block_total;
  logic [ADDR_W-1:0] used_total;

  logic [MAP_AW-1:0]   clr;
  logic                func_q;
  logic [REQ_W-1:0]    req;
  logic [BLK_W-1:0]    lim;
  logic [ZI_W-1:0]     zi;
  logic [BLK_W-1:0]    b;
  logic [BLK_W-1:0]    j;
  logic [ADDR_W-1:0]   a;
  logic [ADDR_W-1:0]   off;
  logic [PROD_W-1:0]   prod;
  logic                last;
  logic [STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]   res_addr;

  logic              ram_we;
  logic [MAP_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  logic [CNT_W-1:0]   cur_count;
  logic [SIZE_W-1:0]  cur_size;
  logic               a_fit;
  logic [CNT_W-1:0]   mul_op;
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [2*MUL_W-1:0] mul_res;
  logic [QUO_W-1:0]   quo_next;
  logic [BLK_W-1:0]   zone_sum;
  logic [BLK_W-1:0]   lim_next;
  logic [7:0]         free_vec;
  logic               hit;
  logic [2:0]         hit_pos;
  logic [7:0]         bit_mask;
  logic               bit_set;
  logic               accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base     <= '0;
      zone_count[0] <= CNT_W'(0);
      zone_count[1] <= CNT_W'(0);
      zone_count[2] <= CNT_W'(0);
      zone_count[3] <= CNT_W'(0);
      zone_count[4] <= CNT_W'(8);
      zone_count[5] <= CNT_W'(2);
      block_total   <= CNT_W'(10);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_POOL_BASE:   pool_base     <= cfg_data;
        REG_COUNT_ZONE0: zone_count[0] <= cfg_data[CNT_W-1:0];
        REG_COUNT_ZONE1: zone_count[1] <= cfg_data[CNT_W-1:0];
        REG_COUNT_ZONE2: zone_count[2] <= cfg_data[CNT_W-1:0];
        REG_COUNT_ZONE3: zone_count[3] <= cfg_data[CNT_W-1:0];
        REG_COUNT_ZONE4: zone_count[4] <= cfg_data[CNT_W-1:0];
        REG_COUNT_ZONE5: zone_count[5] <= cfg_data[CNT_W-1:0];
        REG_BLOCK_TOTAL: block_total   <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Usable block count: the smallest of block_total, the zone sum and the map size.
  always_comb begin
    zone_sum = '0;
    for (int z = 0; z < ZONES; z++) begin
      zone_sum = zone_sum + BLK_W'(zone_count[z]);
    end
    lim_next = BLK_W'(block_total);
    if (lim_next > zone_sum) begin
      lim_next = zone_sum;
    end
    if (lim_next > MAP_BITS) begin
      lim_next = MAP_BITS;
    end
  end

  // Shared zone arithmetic: one multiplier serves the address walk, the free walk and
  // the division of the offset by the 18- and 36-byte block sizes.
  always_comb begin
    cur_count = (zi < ZI_W'(ZONES)) ? zone_count[zi] : '0;
    cur_size  = zone_size(zi);
    a_fit     = (j + BLK_W'(cur_count)) > b;
    mul_op    = (state == S_AMUL && a_fit) ? CNT_W'(b - j) : cur_count;
    if (state == S_FDIV) begin
      mul_a = (zi == 3'd3) ? MUL_W'(off >> 2) : MUL_W'(off >> 1);
      mul_b = DIV9_MUL;
    end else begin
      mul_a = MUL_W'(mul_op);
      mul_b = MUL_W'(cur_size);
    end
    mul_res = mul_a * mul_b;
    // The offset is below count * size, so the quotient fits QUO_W bits.
    case (zi)
      3'd0:    quo_next = QUO_W'(off >> 2);
      3'd1:    quo_next = QUO_W'(off >> 3);
      3'd2:    quo_next = QUO_W'(mul_res >> DIV9_SHIFT);
      3'd3:    quo_next = QUO_W'(mul_res >> DIV9_SHIFT);
      3'd4:    quo_next = QUO_W'(off >> 9);
      default: quo_next = QUO_W'(off / STACK_BLOCK_BYTES);
    endcase
  end

  // A bit is a candidate when it is clear, not before b within the byte, and usable.
  always_comb begin
    for (int p = 0; p < 8; p++) begin
      free_vec[p] = !ram_rdata[7-p] && (3'(p) >= b[2:0]) &&
                    ({b[BLK_W-1:3], 3'(p)} < lim);
    end
    hit     = |free_vec;
    hit_pos = '0;
    for (int p = 7; p >= 0; p--) begin
      if (free_vec[p]) begin
        hit_pos = 3'(p);
      end
    end
    bit_mask = 8'h80 >> b[2:0];
    bit_set  = |(ram_rdata & bit_mask);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = b[MAP_AW+2:3];
    ram_wdata = ram_rdata | (8'h80 >> hit_pos);
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr;
        ram_wdata = 8'h00;
      end
      S_SCAN_CHK: begin
        ram_we = hit;
      end
      S_FCHK: begin
        ram_we    = bit_set;
        ram_wdata = ram_rdata & ~bit_mask;
      end
      default: ;
    endcase
  end

  scba_ram #(
    .WIDTH(8),
    .DEPTH(MAP_BYTES)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(b[MAP_AW+2:3]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      used_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      // In the finish step the output register is reloaded instead.
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == MAP_AW'(MAP_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            func_q <= func;
            req    <= request_bytes;
            off    <= release_address - pool_base;
            state  <= S_LIMIT;
          end
        end
        S_LIMIT: begin
          lim   <= lim_next;
          zi    <= '0;
          b     <= '0;
          j     <= '0;
          a     <= pool_base;
          state <= (func_q == FUNC_FREE) ? S_FMUL : S_AZONE;
        end
        S_AZONE: begin
          if (zi == ZI_W'(ZONES)) begin
            res_status <= ST_OOM;
            res_addr   <= '0;
            state      <= S_FIN;
          end else if (REQ_W'(cur_size) < req) begin
            b  <= b + BLK_W'(cur_count);
            zi <= zi + 1'b1;
          end else begin
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          if (b >= lim) begin
            res_status <= ST_OOM;
            res_addr   <= '0;
            state      <= S_FIN;
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (hit) begin
            b     <= {b[BLK_W-1:3], hit_pos};
            zi    <= '0;
            state <= S_AMUL;
          end else begin
            b     <= {b[BLK_W-1:3] + 1'b1, 3'b000};
            state <= S_SCAN_RD;
          end
        end
        S_AMUL: begin
          // The block lies below the zone sum, so the walk always ends on a fit.
          prod  <= PROD_W'(mul_res);
          last  <= a_fit || (zi >= ZI_W'(ZONES - 1));
          state <= S_AACC;
        end
        S_AACC: begin
          a <= a + ADDR_W'(prod);
          if (last) begin
            used_total <= used_total + ADDR_W'(cur_size);
            res_status <= ST_OK;
            res_addr   <= a + ADDR_W'(prod);
            state      <= S_FIN;
          end else begin
            j     <= j + BLK_W'(cur_count);
            zi    <= zi + 1'b1;
            state <= S_AMUL;
          end
        end
        S_FMUL: begin
          if (zi == ZI_W'(ZONES)) begin
            res_status <= ST_INVALID;
            res_addr   <= '0;
            state      <= S_FIN;
          end else begin
            prod  <= PROD_W'(mul_res);
            state <= S_FCMP;
          end
        end
        S_FCMP: begin
          if (off >= ADDR_W'(prod)) begin
            off   <= off - ADDR_W'(prod);
            b     <= b + BLK_W'(cur_count);
            zi    <= zi + 1'b1;
            state <= S_FMUL;
          end else begin
            state <= S_FDIV;
          end
        end
        S_FDIV: begin
          b     <= b + BLK_W'(quo_next);
          state <= S_FRD;
        end
        S_FRD: begin
          if (b >= lim) begin
            res_status <= ST_INVALID;
            res_addr   <= '0;
            state      <= S_FIN;
          end else begin
            state <= S_FCHK;
          end
        end
        S_FCHK: begin
          // A double free leaves the count alone.
          if (bit_set) begin
            used_total <= used_total - ADDR_W'(cur_size);
          end
          res_status <= ST_OK;
          res_addr   <= '0;
          state      <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            status        <= res_status;
            block_address <= res_addr;
            bytes_in_use  <= used_total;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_LIMIT))
    else $error("accepted item did not start the sequencer");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FIN))
    else $error("result raised outside the finish step");

  a_used_total_source: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(used_total)) |->
      ($past(state) == S_AACC || $past(state) == S_FCHK))
    else $error("used byte count changed outside alloc or free commit");

  a_error_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (block_address == '0))
    else $error("failed item carries a block address");

endmodule

`default_nettype wire

// ----- dv/size_class_bitmap_allocator_top_tb.sv -----
`timescale 1ns / 1ps

module size_class_bitmap_allocator_top_tb;
  import scba_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int HEAP_BITS = MAP_BYTES * 8;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 53;
  localparam int unsigned BLOCK_BYTES [ZONES] = '{4, 8, 18, 36, 512, STACK_BLOCK_BYTES};
  localparam int SEND_IDLE [4] = '{0, 50, 0, 25};
  localparam int RECV_STALL [4] = '{0, 0, 50, 25};

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   addr;
    logic [ADDR_W-1:0]   used;
  } reply_t;

  typedef struct packed {
    logic                 is_write;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [ADDR_W-1:0]    reg_val;
    logic                 op;
    logic [REQ_W-1:0]     req;
    logic [ADDR_W-1:0]    rel;
    logic                 known;
    reply_t               reply;
  } plan_row_t;

  // Register writes wait for the block to go idle. Rows with a typed reply are
  // checked against it; all others against the heap model.
  localparam plan_row_t PLAN [39] = '{
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_ALLOC, 16'd0, 32'h0, 1'b1,
      '{ST_OK, 32'h0, 32'd512}},
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_ALLOC, 16'hffff, 32'hffff_ffff, 1'b1,
      '{ST_OOM, 32'h0, 32'd512}},
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_FREE, 16'd0, 32'hffff_ffff, 1'b1,
      '{ST_INVALID, 32'h0, 32'd512}},
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_FREE, 16'hffff, 32'h0, 1'b1,
      '{ST_OK, 32'h0, 32'd0}},
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_FREE, 16'd0, 32'h0, 1'b1,
      '{ST_OK, 32'h0, 32'd0}},
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_ALLOC, 16'd1024, 32'ha5a5_a5a5, 1'b0, '0},
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_ALLOC, 16'd1025, 32'h0, 1'b0, '0},
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_ALLOC, 16'd1024, 32'h5a5a_5a5a, 1'b0, '0},
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_ALLOC, 16'd1024, 32'h0, 1'b0, '0},
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_FREE, 16'd7, 32'd5121, 1'b0, '0},
    '{1'b1, REG_BLOCK_TOTAL, 32'd9, FUNC_ALLOC, 16'd0, 32'h0, 1'b0, '0},
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_FREE, 16'd0, 32'd5120, 1'b0, '0},
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_ALLOC, 16'd1, 32'h0, 1'b0, '0},
    '{1'b1, REG_POOL_BASE, 32'hffff_ff00, FUNC_ALLOC, 16'd0, 32'h0, 1'b0, '0},
    '{1'b1, REG_COUNT_ZONE0, 32'd3, FUNC_ALLOC, 16'd0, 32'h0, 1'b0, '0},
    '{1'b1, REG_COUNT_ZONE1, 32'd2, FUNC_ALLOC, 16'd0, 32'h0, 1'b0, '0},
    '{1'b1, REG_COUNT_ZONE2, 32'd2, FUNC_ALLOC, 16'd0, 32'h0, 1'b0, '0},
    '{1'b1, REG_COUNT_ZONE3, 32'd1, FUNC_ALLOC, 16'd0, 32'h0, 1'b0, '0},
    '{1'b1, REG_COUNT_ZONE4, 32'd1, FUNC_ALLOC, 16'd0, 32'h0, 1'b0, '0},
    '{1'b1, REG_COUNT_ZONE5, 32'd1, FUNC_ALLOC, 16'd0, 32'h0, 1'b0, '0},
    '{1'b1, REG_BLOCK_TOTAL, 32'd8192, FUNC_ALLOC, 16'd0, 32'h0, 1'b0, '0},
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_ALLOC, 16'd4, 32'h0, 1'b0, '0},
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_ALLOC, 16'd5, 32'h0, 1'b0, '0},
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_ALLOC, 16'd18, 32'h0, 1'b0, '0},
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_ALLOC, 16'd36, 32'h0, 1'b0, '0},
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_ALLOC, 16'd512, 32'h0, 1'b0, '0},
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_ALLOC, 16'd37, 32'h0, 1'b0, '0},
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_FREE, 16'd0, 32'hffff_feff, 1'b0, '0},
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_FREE, 16'd0, 32'hffff_ff30, 1'b0, '0},
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_FREE, 16'd0, 32'h0000_0564, 1'b0, '0},
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_ALLOC, 16'd0, 32'h0, 1'b0, '0},
    '{1'b1, REG_COUNT_ZONE0, 32'd0, FUNC_ALLOC, 16'd0, 32'h0, 1'b0, '0},
    '{1'b1, REG_COUNT_ZONE1, 32'd0, FUNC_ALLOC, 16'd0, 32'h0, 1'b0, '0},
    '{1'b1, REG_COUNT_ZONE2, 32'd0, FUNC_ALLOC, 16'd0, 32'h0, 1'b0, '0},
    '{1'b1, REG_COUNT_ZONE3, 32'd0, FUNC_ALLOC, 16'd0, 32'h0, 1'b0, '0},
    '{1'b1, REG_COUNT_ZONE4, 32'd0, FUNC_ALLOC, 16'd0, 32'h0, 1'b0, '0},
    '{1'b1, REG_COUNT_ZONE5, 32'd0, FUNC_ALLOC, 16'd0, 32'h0, 1'b0, '0},
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_ALLOC, 16'd3, 32'h0, 1'b0, '0},
    '{1'b0, REG_POOL_BASE, 32'h0, FUNC_FREE, 16'd0, 32'hffff_ff00, 1'b0, '0}
  };

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 func;
  logic [REQ_W-1:0]     request_bytes;
  logic [ADDR_W-1:0]    release_address;
  logic                 out_valid;
  logic                 out_stall;
  logic [STATUS_W-1:0]  status;
  logic [ADDR_W-1:0]    block_address;
  logic [ADDR_W-1:0]    bytes_in_use;

  // Heap model state and its copy of the registers.
  bit          occupied [HEAP_BITS];
  logic [31:0] model_used;
  logic [31:0] heap_base;
  int unsigned zone_blocks [ZONES];
  int unsigned blocks_limit;

  reply_t pending_replies [$];
  int     errors = 0;
  int     send_idle_pct = 0;
  int     stall_pct = 0;
  int     quiet_cycles = 0;

  size_class_bitmap_allocator_top DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .func            (func),
    .request_bytes   (request_bytes),
    .release_address (release_address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .block_address   (block_address),
    .bytes_in_use    (bytes_in_use)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned live_blocks();
    int unsigned sum;
    int unsigned lim;
    sum = 0;
    for (int z = 0; z < ZONES; z++) sum += zone_blocks[z];
    lim = blocks_limit;
    if (lim > sum) lim = sum;
    if (lim > HEAP_BITS) lim = HEAP_BITS;
    return lim;
  endfunction

  // Byte address of block b and the zone that holds it.
  function automatic logic [31:0] block_base(input int unsigned b, output int zone);
    logic [31:0] a;
    int unsigned first;
    a = heap_base;
    first = 0;
    zone = ZONES;
    for (int z = 0; z < ZONES; z++) begin
      if (zone == ZONES) begin
        if (first + zone_blocks[z] <= b) begin
          first += zone_blocks[z];
          a += 32'(zone_blocks[z] * BLOCK_BYTES[z]);
        end else begin
          a += 32'(BLOCK_BYTES[z] * (b - first));
          zone = z;
        end
      end
    end
    return a;
  endfunction

  function automatic reply_t heap_step(input logic op, input logic [REQ_W-1:0] req,
                                       input logic [ADDR_W-1:0] rel);
    reply_t      r;
    int unsigned lim;
    int unsigned b;
    int          z;
    logic [31:0] off;
    r.status = ST_OK;
    r.addr = '0;
    lim = live_blocks();
    b = 0;
    z = 0;
    if (op == FUNC_ALLOC) begin
      while (z < ZONES && BLOCK_BYTES[z] < req) begin
        b += zone_blocks[z];
        z++;
      end
      if (z == ZONES) begin
        r.status = ST_OOM;
      end else begin
        while (b < lim && occupied[b]) b++;
        if (b >= lim) begin
          r.status = ST_OOM;
        end else begin
          r.addr = block_base(b, z);
          occupied[b] = 1'b1;
          model_used += BLOCK_BYTES[z];
        end
      end
    end else begin
      off = rel - heap_base;
      while (z < ZONES && off >= 32'(zone_blocks[z] * BLOCK_BYTES[z])) begin
        off -= 32'(zone_blocks[z] * BLOCK_BYTES[z]);
        b += zone_blocks[z];
        z++;
      end
      if (z == ZONES) begin
        r.status = ST_INVALID;
      end else begin
        b += off / BLOCK_BYTES[z];
        if (b >= lim) begin
          r.status = ST_INVALID;
        end else if (occupied[b]) begin
          occupied[b] = 1'b0;
          model_used -= BLOCK_BYTES[z];
        end
      end
    end
    r.used = model_used;
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_POOL_BASE: heap_base = val;
      REG_BLOCK_TOTAL: blocks_limit = val[CNT_W-1:0];
      default: zone_blocks[idx - REG_COUNT_ZONE0] = val[CNT_W-1:0];
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Called in the time step of the previous acceptance, so valid either drops
  // or carries the next item without a gap.
  task automatic send_item(input logic op, input logic [REQ_W-1:0] req,
                           input logic [ADDR_W-1:0] rel, input logic known,
                           input reply_t want);
    reply_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= op;
    request_bytes <= req;
    release_address <= rel;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = heap_step(op, req, rel);
    pending_replies.push_back(known ? want : predicted);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic random_config(input int p);
    int unsigned counts [ZONES];
    int unsigned sum;
    logic [31:0] base;
    logic [31:0] total;
    sum = 0;
    for (int z = 0; z < ZONES; z++) begin
      case ($urandom_range(7))
        0: counts[z] = 0;
        1: counts[z] = 8192;
        2: counts[z] = $urandom_range(8192);
        default: counts[z] = $urandom_range(24, 1);
      endcase
      if (p == 0) counts[z] = 8192;
      sum += counts[z];
    end
    case ($urandom_range(9))
      0: base = '0;
      1: base = '1;
      default: base = $urandom;
    endcase
    // Software normally writes the sum of the zone counts.
    case ($urandom_range(15))
      0: total = 0;
      1: total = $urandom_range(8192);
      2: total = 8192;
      default: total = (sum > 8192) ? 8192 : sum;
    endcase
    write_reg(REG_POOL_BASE, base);
    for (int z = 0; z < ZONES; z++) write_reg(REG_COUNT_ZONE0 + 3'(z), counts[z]);
    write_reg(REG_BLOCK_TOTAL, total);
  endtask

  // Mostly allocations sized around the zone sizes and frees of blocks that
  // are held, with some stray addresses and oversized requests.
  task automatic random_item();
    int unsigned      lim;
    int unsigned      b;
    int unsigned      pick;
    int               z;
    bit               found;
    logic             op;
    logic [REQ_W-1:0] req;
    logic [ADDR_W-1:0] rel;
    req = REQ_W'($urandom);
    rel = $urandom;
    op = FUNC_ALLOC;
    pick = $urandom_range(99);
    if (pick < 50) begin
      z = $urandom_range(ZONES - 1);
      case ($urandom_range(3))
        0: req = REQ_W'(BLOCK_BYTES[z]);
        1: req = REQ_W'(BLOCK_BYTES[z] + 1);
        default: req = REQ_W'($urandom_range(BLOCK_BYTES[z]));
      endcase
    end else if (pick < 85) begin
      op = FUNC_FREE;
      lim = live_blocks();
      if (lim != 0) begin
        b = $urandom_range(lim - 1);
        found = 1'b0;
        for (int unsigned k = 0; k < lim && !found; k++) begin
          if (occupied[(b + k) % lim]) begin
            b = (b + k) % lim;
            found = 1'b1;
          end
        end
        rel = block_base(b, z);
        rel += $urandom_range(BLOCK_BYTES[z] - 1);
      end
    end else if (pick < 93) begin
      op = FUNC_FREE;
    end
    send_item(op, req, rel, 1'b0, '0);
  endtask

  always @(posedge clk) begin : reply_check
    reply_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected item: status %0d, block_address %h, bytes_in_use %0d",
               status, block_address, bytes_in_use);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (block_address !== want.addr) begin
          $error("block_address: expected %h, got %h", want.addr, block_address);
          errors++;
        end
        if (bytes_in_use !== want.used) begin
          $error("bytes_in_use: expected %0d, got %0d", want.used, bytes_in_use);
          errors++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("size_class_bitmap_allocator_top_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_POOL_BASE;
    cfg_data = '0;
    in_valid = 1'b0;
    func = FUNC_ALLOC;
    request_bytes = '0;
    release_address = '0;
    heap_base = '0;
    zone_blocks = '{0, 0, 0, 0, 8, 2};
    blocks_limit = 10;
    model_used = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (PLAN[i]) begin
      if (PLAN[i].is_write) begin
        wait_idle();
        write_reg(PLAN[i].reg_idx, PLAN[i].reg_val);
      end else begin
        send_item(PLAN[i].op, PLAN[i].req, PLAN[i].rel, PLAN[i].known, PLAN[i].reply);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      random_config(p);
      send_idle_pct = SEND_IDLE[p % 4];
      stall_pct = RECV_STALL[p % 4];
      repeat (ITEMS_PER_PHASE) random_item();
    end

    wait_idle();
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("size_class_bitmap_allocator_top_tb: PASS");
    else
      $display("size_class_bitmap_allocator_top_tb: FAIL");
    $finish;
  end

endmodule
